### hdl/msp_pkg.sv
// Shared types, codes and arithmetic helpers for the motor speed PID controller.
`timescale 1ns / 1ps
`default_nettype none
package msp_pkg;

  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int DIV_W   = 32;
  localparam int DVS_W   = 8;

  localparam logic [15:0] GLITCH_SPEED = 16'd65530;
  localparam logic [9:0]  MS_PER_S     = 10'd1000;

  typedef enum logic [1:0] {
    ST_CORRECTED = 2'd0,
    ST_CUT       = 2'd1,
    ST_GLITCH    = 2'd2
  } status_t;

  localparam logic [1:0] OVR_NONE     = 2'd0;
  localparam logic [1:0] OVR_START    = 2'd1;
  localparam logic [1:0] OVR_CANCEL   = 2'd2;
  localparam logic [1:0] OVR_RESERVED = 2'd3;

  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_PROT_MIN  = 3'd3;
  localparam logic [2:0] REG_SOFT_LOW  = 3'd4;
  localparam logic [2:0] REG_SOFT_HIGH = 3'd5;
  localparam logic [2:0] REG_HARD_LOW  = 3'd6;
  localparam logic [2:0] REG_HARD_HIGH = 3'd7;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
    if (v > 33'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -33'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  function automatic logic signed [15:0] scale16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] adj;
    logic signed [PROD_W-1:0] sh;
    adj = p[PROD_W-1] ? p + PROD_W'(65535) : p;
    sh  = adj >>> 16;
    if (sh > PROD_W'(32767)) begin
      scale16 = 16'sh7fff;
    end else if (sh < -PROD_W'(32768)) begin
      scale16 = 16'sh8000;
    end else begin
      scale16 = sh[15:0];
    end
  endfunction

endpackage
`default_nettype wire

### hdl/msp_mul.sv
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module msp_mul
  import msp_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic signed [MUL_A_W-1:0] a,
  input  wire logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]       p
);

  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule
`default_nettype wire

### hdl/msp_div.sv
// Shared unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module msp_div
  import msp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] q;
  logic [DVS_W-1:0] r;
  logic [DVS_W-1:0] dvs;
  logic             done;
  logic [DVS_W:0]   r_sh;

  assign r_sh = {r, q[DIV_W-1]};
  assign rsp.done = done;
  assign rsp.quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !req.start && (cnt == CNT_W'(DIV_W - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q   <= req.dividend;
      r   <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (r_sh >= {1'b0, dvs}) begin
        r <= DVS_W'(r_sh - {1'b0, dvs});
        q <= {q[DIV_W-2:0], 1'b1};
      end else begin
        r <= r_sh[DVS_W-1:0];
        q <= {q[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

### hdl/motor_speed_pid_controller.sv
// Top level of the motor speed PID controller: sequencer, state and registers.
`timescale 1ns / 1ps
`default_nettype none
// One control tick per input transaction. A tick runs on a small sequencer around one shared
// 33x25 multiplier and one serial divider that produces one quotient bit per cycle; the three
// 32-step divisions (speed, average error, derivative) set the latency. A corrected tick runs
// all three divisions before it loads its result into the output register, a protection cut
// or glitch skip only the speed division; the block then returns to idle before the next
// transaction can be taken. The block takes no new transaction until the current result is
// in the output register, which holds it until the receiver takes it; a stalled output
// register adds its stall to the next tick.
module motor_speed_pid_controller
  import msp_pkg::*;
#(
  parameter int AVG_DEPTH   = 10,
  parameter int FORCE_TICKS = 50
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [23:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] encoder_count,
  input  wire logic [7:0]         elapsed_ms,
  input  wire logic signed [15:0] new_target,
  input  wire logic               load_target,
  input  wire logic [1:0]         override_cmd,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [15:0]             motor_power,
  output logic signed [23:0]      speed_estimate,
  output logic [1:0]              tick_status
);

  localparam int FILL_W = $clog2(AVG_DEPTH + 1);
  localparam int PTR_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int SUM_W  = 25 + $clog2(AVG_DEPTH);

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001,
    S_MSPD = 17'h00002,
    S_DSPD = 17'h00004,
    S_WSPD = 17'h00008,
    S_DEC  = 17'h00010,
    S_MTGT = 17'h00020,
    S_DDIF = 17'h00040,
    S_WDIF = 17'h00080,
    S_MP   = 17'h00100,
    S_MI1  = 17'h00200,
    S_INTG = 17'h00400,
    S_MI2  = 17'h00800,
    S_DD   = 17'h01000,
    S_WDD  = 17'h02000,
    S_MD   = 17'h04000,
    S_SUM  = 17'h08000,
    S_OUT  = 17'h10000
  } state_t;

  state_t state;

  logic [23:0] gain_p, gain_i, gain_d;
  logic [15:0] protect_min_speed, soft_low, soft_high, hard_low, hard_high;

  logic signed [15:0]    target_speed;
  logic signed [23:0]    hist [AVG_DEPTH];
  logic [PTR_W-1:0]      hist_wr;
  logic [FILL_W-1:0]     hist_fill;
  logic signed [SUM_W-1:0] hist_sum;
  logic signed [31:0]    error_integral;
  logic signed [15:0]    previous_error;
  logic [7:0]            force_countdown;
  logic [15:0]           held_power;

  logic signed [15:0] count;
  logic [7:0]         elapsed;
  logic signed [23:0] speed;
  logic signed [15:0] diff;
  logic signed [15:0] dquot;
  logic signed [15:0] pterm, iterm;
  status_t            status;
  logic               div_neg;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  div_req_t                  dreq;
  div_rsp_t                  drsp;

  logic signed [32:0] sval;
  logic [DIV_W-1:0]   smag;
  logic signed [32:0] qsig;
  logic signed [23:0] spd_sat;
  logic [23:0]        spd_abs;
  logic signed [32:0] sum33;
  logic signed [32:0] sum_abs;
  logic [15:0]        soft_v;
  logic signed [15:0] dterm;
  logic signed [18:0] psum;
  logic signed [18:0] hard_t;
  logic [15:0]        hard_v;
  logic signed [33:0] int_t;
  logic signed [31:0] int_sat;
  logic [15:0]        hold_v;

  msp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));
  msp_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign in_stall = (state != S_IDLE);

  always_comb begin
    sum33   = 33'(hist_sum);
    sum_abs = (sum33 < 0) ? -sum33 : sum33;
    case (state)
      S_DSPD:  sval = 33'(prod);
      S_DDIF:  sval = 33'(prod) - sum_abs;
      S_DD:    sval = 33'(diff) - 33'(previous_error);
      default: sval = '0;
    endcase
    smag = (sval < 0) ? DIV_W'(-sval) : DIV_W'(sval);
    dreq.start    = (state == S_DSPD) || (state == S_DDIF) || (state == S_DD);
    dreq.dividend = smag;
    dreq.divisor  = (state == S_DDIF) ? DVS_W'(hist_fill) : elapsed;
    qsig = div_neg ? -$signed({1'b0, drsp.quotient}) : $signed({1'b0, drsp.quotient});
    if (qsig > 33'sd8388607) begin
      spd_sat = 24'sh7fffff;
    end else if (qsig < -33'sd8388608) begin
      spd_sat = 24'sh800000;
    end else begin
      spd_sat = qsig[23:0];
    end
    spd_abs = (speed < 0) ? 24'(-speed) : 24'(speed);
  end

  always_comb begin
    case (state)
      S_MSPD: begin
        mul_a = 33'(count);
        mul_b = 25'(MS_PER_S);
      end
      S_MTGT: begin
        mul_a = (target_speed < 0) ? -33'(target_speed) : 33'(target_speed);
        mul_b = 25'(hist_fill);
      end
      S_MP: begin
        mul_a = 33'(diff);
        mul_b = $signed({1'b0, gain_p});
      end
      S_MI1: begin
        mul_a = 33'(diff);
        mul_b = 25'(elapsed);
      end
      S_MI2: begin
        mul_a = 33'(error_integral);
        mul_b = $signed({1'b0, gain_i});
      end
      S_MD: begin
        mul_a = 33'(dquot);
        mul_b = $signed({1'b0, gain_d});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    soft_v = held_power;
    if (soft_v < soft_low) soft_v = soft_low;
    if (soft_v > soft_high) soft_v = soft_high;
    dterm = scale16(prod);
    psum  = $signed({3'b000, held_power}) + 19'(pterm) + 19'(iterm) + 19'(dterm);
    hard_t = (psum < $signed({3'b000, hard_low})) ? $signed({3'b000, hard_low}) : psum;
    if (hard_t > $signed({3'b000, hard_high})) begin
      hard_v = hard_high;
    end else begin
      hard_v = hard_t[15:0];
    end
    int_t = 34'(error_integral) + 34'(prod);
    if (int_t > 34'sd2147483647) begin
      int_sat = 32'sh7fffffff;
    end else if (int_t < -34'sd2147483648) begin
      int_sat = 32'sh80000000;
    end else begin
      int_sat = int_t[31:0];
    end
    hold_v = held_power;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p            <= 24'd130;
      gain_i            <= 24'd131;
      gain_d            <= 24'd23;
      protect_min_speed <= 16'd10;
      soft_low          <= 16'd0;
      soft_high         <= 16'd500;
      hard_low          <= 16'd0;
      hard_high         <= 16'd1000;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GAIN_P:    gain_p            <= cfg_data;
        REG_GAIN_I:    gain_i            <= cfg_data;
        REG_GAIN_D:    gain_d            <= cfg_data;
        REG_PROT_MIN:  protect_min_speed <= cfg_data[15:0];
        REG_SOFT_LOW:  soft_low          <= cfg_data[15:0];
        REG_SOFT_HIGH: soft_high         <= cfg_data[15:0];
        REG_HARD_LOW:  hard_low          <= cfg_data[15:0];
        REG_HARD_HIGH: hard_high         <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (dreq.start) div_neg <= (sval < 0);
    if (state == S_IDLE && in_valid) begin
      count   <= encoder_count;
      elapsed <= (elapsed_ms == 8'd0) ? 8'd1 : elapsed_ms;
    end
    if (state == S_WSPD && drsp.done) begin
      speed <= spd_sat;
      hist[hist_wr] <= spd_sat;
    end
    if (state == S_WDIF && drsp.done) diff <= sat16(qsig);
    if (state == S_MI1) pterm <= scale16(prod);
    if (state == S_DD) iterm <= scale16(prod);
    if (state == S_WDD && drsp.done) dquot <= sat16(qsig);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      target_speed    <= '0;
      hist_wr         <= '0;
      hist_fill       <= '0;
      hist_sum        <= '0;
      error_integral  <= '0;
      previous_error  <= '0;
      force_countdown <= '0;
      held_power      <= '0;
      status          <= ST_CORRECTED;
      out_valid       <= 1'b0;
      motor_power     <= '0;
      speed_estimate  <= '0;
      tick_status     <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (override_cmd == OVR_START) begin
              force_countdown <= 8'(FORCE_TICKS);
            end else if (override_cmd == OVR_CANCEL) begin
              force_countdown <= '0;
            end
            if (load_target) target_speed <= new_target;
            held_power <= soft_v;
            state      <= S_MSPD;
          end
        end
        S_MSPD: state <= S_DSPD;
        S_DSPD: state <= S_WSPD;
        S_WSPD: begin
          if (drsp.done) begin
            if (hist_fill >= FILL_W'(AVG_DEPTH)) begin
              hist_sum <= hist_sum - SUM_W'(hist[hist_wr]) + SUM_W'(spd_sat);
            end else begin
              hist_fill <= hist_fill + 1'b1;
              hist_sum  <= hist_sum + SUM_W'(spd_sat);
            end
            hist_wr <= (hist_wr == PTR_W'(AVG_DEPTH - 1)) ? '0 : hist_wr + 1'b1;
            if (force_countdown != 8'd0) force_countdown <= force_countdown - 1'b1;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          if (spd_abs < {8'd0, protect_min_speed} && force_countdown == 8'd0) begin
            held_power <= '0;
            status     <= ST_CUT;
            state      <= S_OUT;
          end else if (speed > $signed({8'd0, GLITCH_SPEED})) begin
            status <= ST_GLITCH;
            state  <= S_OUT;
          end else begin
            status <= ST_CORRECTED;
            state  <= S_MTGT;
          end
        end
        S_MTGT: state <= S_DDIF;
        S_DDIF: state <= S_WDIF;
        S_WDIF: if (drsp.done) state <= S_MP;
        S_MP:   state <= S_MI1;
        S_MI1:  state <= S_INTG;
        S_INTG: begin
          error_integral <= int_sat;
          state          <= S_MI2;
        end
        S_MI2: state <= S_DD;
        S_DD:  state <= S_WDD;
        S_WDD: if (drsp.done) state <= S_MD;
        S_MD:  state <= S_SUM;
        S_SUM: begin
          held_power     <= hard_v;
          previous_error <= diff;
          state          <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            motor_power    <= hold_v;
            speed_estimate <= speed;
            tick_status    <= status;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/msp_checker.sv
// Port-level checks for the motor speed PID controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module msp_checker
  import msp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] motor_power,
  input wire logic [1:0]  tick_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("new transaction taken while a tick is in work");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tick_status == ST_CORRECTED || tick_status == ST_CUT ||
                   tick_status == ST_GLITCH))
    else $error("unused status code");

  a_cut_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && tick_status == ST_CUT |-> motor_power == 16'd0)
    else $error("protection cut with nonzero power");

endmodule

bind motor_speed_pid_controller msp_checker u_msp_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .motor_power(motor_power),
  .tick_status(tick_status)
);
`default_nettype wire
